@@ sv/grid_local_peak_finder_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the grid local peak finder
// Clocked concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_LOCAL_PEAK_FINDER_CORE_ASSERT_SVH
`define GRID_LOCAL_PEAK_FINDER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define GLPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GLPF_ASSERT_NEVER(label, cond, msg) \
    `GLPF_ASSERT(label, !(cond), msg)
`else
`define GLPF_ASSERT(label, prop, msg)
`define GLPF_ASSERT_NEVER(label, cond, msg)
`endif

`endif

@@ sv/glpf_pkg.sv @@
// ----------------------------------------------------------------------------
// glpf_pkg
// Shared constants and types of the grid local peak finder.
// ----------------------------------------------------------------------------
package glpf_pkg;

    localparam int MAX_COLS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int ROW_W       = 12;
    localparam int COLS_W      = 7;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ADDR_W      = COL_W - 1;
    localparam int HALF_COLS   = (MAX_COLS + 1) / 2;
    localparam int STORES      = 3;
    localparam int ROT_W       = 2;
    localparam int GROUP       = 3;
    localparam int MIN_DIM     = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    localparam logic [ROW_W-1:0]  GRID_ROWS_RESET = ROW_W'(MIN_DIM);
    localparam logic [COLS_W-1:0] GRID_COLS_RESET = COLS_W'(MIN_DIM);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [STORES-1:0][SAMPLE_BITS-1:0] word_t;
    typedef logic [ROT_W-1:0] slot_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } peak_t;

    function automatic logic ge(sample_t a, sample_t b);
        return a >= b;
    endfunction

endpackage

@@ sv/glpf_sample_if.sv @@
// ----------------------------------------------------------------------------
// glpf_sample_if
// Sample request channel: valid/ready with one signed grid sample.
// ----------------------------------------------------------------------------
interface glpf_sample_if
    import glpf_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ sv/glpf_peak_if.sv @@
// ----------------------------------------------------------------------------
// glpf_peak_if
// Peak request channel: valid/ready with peak coordinates and run marker.
// ----------------------------------------------------------------------------
interface glpf_peak_if
    import glpf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] peak_row;
    logic [COL_W-1:0] peak_col;
    logic             last_of_run;

    modport source (output valid, output peak_row, output peak_col, output last_of_run,
                    input ready);
    modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
                    output ready);
endinterface

@@ sv/grid_local_peak_finder_core.sv @@
// ----------------------------------------------------------------------------
// grid_local_peak_finder_core
// 4-neighbour local maximum detection on a row-major stream of signed samples.
// ----------------------------------------------------------------------------
//  channel   dir   payload                          handshake
//  samples   sink  sample                           valid/ready
//  peaks     src   peak_row, peak_col, last_of_run  valid/ready
//  cfg       in    cfg_index, cfg_data              cfg_we, no wait
//
//  One sample per clock when not stalled. Each accepted sample writes its row store
//  slot and reads four column words from two dual-read memories (even/odd columns);
//  the decision stage takes it in the next cycle. Results leave one per clock from
//  the output register while peaks.ready is high; in the last row a sample can
//  raise two or three results, and samples stall while they drain. Reset clears
//  counters and presets config; the row stores are not cleared.
// ----------------------------------------------------------------------------
`include "grid_local_peak_finder_core_assert.svh"

module grid_local_peak_finder_core
    import glpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    glpf_sample_if.sink           samples,
    glpf_peak_if.source           peaks
);

    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic c_ge1;
        logic c_ge2;
        logic c_not_last;
        logic last_row;
    } flags_t;

    // config and position state
    logic [ROW_W-1:0]  grid_rows_reg;
    logic [COLS_W-1:0] grid_cols_reg;
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;
    logic [COL_W-1:0]  col_pos_reg, col_pos_next;
    slot_t             rot_reg, rot_next;

    logic [ROW_W-1:0]  rows_eff, rows_last, cur_row;
    logic [COLS_W-1:0] cols_eff;
    logic [COL_W-1:0]  cols_last, cur_col, col_m1, col_p1, col_m2;
    slot_t             slot_prv, slot_old;
    flags_t            flags;
    logic              in_accept;

    // row store memories
    word_t             mem_even [HALF_COLS];
    word_t             mem_odd  [HALF_COLS];
    logic [ADDR_W-1:0] even_a0, even_a1, odd_a0, odd_a1, wr_addr;
    word_t             even_q0_reg, even_q1_reg, odd_q0_reg, odd_q1_reg;

    // decision stage
    logic              s1_valid_reg;
    sample_t           s1_sample_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    flags_t            s1_flags_reg;
    slot_t             s1_cur_reg, s1_prv_reg, s1_old_reg;
    word_t             word_c, word_cm1, word_cp1, word_cm2;
    sample_t           prv_c, old_c, prv_cm1, prv_cp1, cur_cm1, cur_cm2;
    logic              ok_a, ok_b, ok_c;
    logic [GROUP-1:0]  group_mask;
    logic              s1_adv;

    // output register
    logic [GROUP-1:0]  s2_mask_reg, s2_mask_next;
    peak_t             s2_peak_reg [GROUP];
    logic              s2_single, s2_free, s2_load, out_accept;
    peak_t             out_peak;

    always_comb
    begin
        rows_eff  = (grid_rows_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : grid_rows_reg;
        rows_last = rows_eff - ROW_W'(1);
        if (grid_cols_reg < COLS_W'(MIN_DIM))
        begin
            cols_eff = COLS_W'(MIN_DIM);
        end
        else if (grid_cols_reg > COLS_W'(MAX_COLS))
        begin
            cols_eff = COLS_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = grid_cols_reg;
        end
        cols_last = COL_W'(cols_eff - COLS_W'(1));

        cur_row = (row_pos_reg > rows_last) ? rows_last : row_pos_reg;
        cur_col = (col_pos_reg > cols_last) ? cols_last : col_pos_reg;
        col_m1  = cur_col - COL_W'(1);
        col_p1  = cur_col + COL_W'(1);
        col_m2  = cur_col - COL_W'(2);

        slot_prv = (rot_reg == slot_t'(0)) ? slot_t'(STORES - 1) : rot_reg - slot_t'(1);
        slot_old = (rot_reg == slot_t'(STORES - 1)) ? slot_t'(0) : rot_reg + slot_t'(1);

        flags.r_ge1      = cur_row != '0;
        flags.r_ge2      = cur_row > ROW_W'(1);
        flags.c_ge1      = cur_col != '0;
        flags.c_ge2      = cur_col > COL_W'(1);
        flags.c_not_last = cur_col != cols_last;
        flags.last_row   = cur_row == rows_last;

        wr_addr = cur_col[COL_W-1:1];
        if (cur_col[0])
        begin
            even_a0 = col_m1[COL_W-1:1];
            even_a1 = col_p1[COL_W-1:1];
            odd_a0  = cur_col[COL_W-1:1];
            odd_a1  = col_m2[COL_W-1:1];
        end
        else
        begin
            even_a0 = cur_col[COL_W-1:1];
            even_a1 = col_m2[COL_W-1:1];
            odd_a0  = col_m1[COL_W-1:1];
            odd_a1  = col_p1[COL_W-1:1];
        end

        if (flags.c_not_last)
        begin
            col_pos_next = cur_col + COL_W'(1);
            row_pos_next = cur_row;
            rot_next     = rot_reg;
        end
        else
        begin
            col_pos_next = '0;
            row_pos_next = flags.last_row ? '0 : cur_row + ROW_W'(1);
            rot_next     = slot_old;
        end
    end

    assign in_accept = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_ROWS_RESET;
            grid_cols_reg <= GRID_COLS_RESET;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            rot_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_ROWS: grid_rows_reg <= cfg_data[ROW_W-1:0];
                    REG_GRID_COLS: grid_cols_reg <= cfg_data[COLS_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept)
            begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
                rot_reg     <= rot_next;
            end
        end
    end

    // current-row slot written in place; reads see all earlier requests
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (!cur_col[0])
            begin
                mem_even[wr_addr][rot_reg] <= samples.sample;
            end
            even_q0_reg <= mem_even[even_a0];
            even_q1_reg <= mem_even[even_a1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (cur_col[0])
            begin
                mem_odd[wr_addr][rot_reg] <= samples.sample;
            end
            odd_q0_reg <= mem_odd[odd_a0];
            odd_q1_reg <= mem_odd[odd_a1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= samples.sample;
            s1_row_reg    <= cur_row;
            s1_col_reg    <= cur_col;
            s1_flags_reg  <= flags;
            s1_cur_reg    <= rot_reg;
            s1_prv_reg    <= slot_prv;
            s1_old_reg    <= slot_old;
        end
    end

    always_comb
    begin
        word_c   = s1_col_reg[0] ? odd_q0_reg  : even_q0_reg;
        word_cm2 = s1_col_reg[0] ? odd_q1_reg  : even_q1_reg;
        word_cm1 = s1_col_reg[0] ? even_q0_reg : odd_q0_reg;
        word_cp1 = s1_col_reg[0] ? even_q1_reg : odd_q1_reg;

        prv_c   = word_c[s1_prv_reg];
        old_c   = word_c[s1_old_reg];
        prv_cm1 = word_cm1[s1_prv_reg];
        prv_cp1 = word_cp1[s1_prv_reg];
        cur_cm1 = word_cm1[s1_cur_reg];
        cur_cm2 = word_cm2[s1_cur_reg];

        // cell above, cell to the left in the last row, last cell of the last row
        ok_a = s1_flags_reg.r_ge1 && ge(prv_c, s1_sample_reg)
            && (!s1_flags_reg.r_ge2 || ge(prv_c, old_c))
            && (!s1_flags_reg.c_ge1 || ge(prv_c, prv_cm1))
            && (!s1_flags_reg.c_not_last || ge(prv_c, prv_cp1));
        ok_b = s1_flags_reg.r_ge1 && s1_flags_reg.last_row && s1_flags_reg.c_ge1
            && ge(cur_cm1, prv_cm1) && ge(cur_cm1, s1_sample_reg)
            && (!s1_flags_reg.c_ge2 || ge(cur_cm1, cur_cm2));
        ok_c = s1_flags_reg.r_ge1 && s1_flags_reg.last_row && !s1_flags_reg.c_not_last
            && ge(s1_sample_reg, prv_c) && ge(s1_sample_reg, cur_cm1);

        group_mask = {ok_c, ok_b, ok_a};
    end

    assign out_accept = peaks.valid && peaks.ready;
    assign s2_single  = (s2_mask_reg != '0)
                        && ((s2_mask_reg & (s2_mask_reg - GROUP'(1))) == '0);
    assign s2_free    = (s2_mask_reg == '0) || (peaks.ready && s2_single);
    assign s2_load    = s1_valid_reg && (group_mask != '0) && s2_free;
    assign s1_adv     = !s1_valid_reg || (group_mask == '0) || s2_free;
    assign samples.ready = s1_adv;

    always_comb
    begin
        if (s2_load)
        begin
            s2_mask_next = group_mask;
        end
        else if (out_accept)
        begin
            s2_mask_next = s2_mask_reg & (s2_mask_reg - GROUP'(1));
        end
        else
        begin
            s2_mask_next = s2_mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_mask_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= in_accept || (s1_valid_reg && !s1_adv);
            s2_mask_reg  <= s2_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_peak_reg[0] <= '{row: s1_row_reg - ROW_W'(1), col: s1_col_reg};
            s2_peak_reg[1] <= '{row: s1_row_reg, col: s1_col_reg - COL_W'(1)};
            s2_peak_reg[2] <= '{row: s1_row_reg, col: s1_col_reg};
        end
    end

    always_comb
    begin
        if (s2_mask_reg[0])
        begin
            out_peak = s2_peak_reg[0];
        end
        else if (s2_mask_reg[1])
        begin
            out_peak = s2_peak_reg[1];
        end
        else
        begin
            out_peak = s2_peak_reg[2];
        end
    end

    assign peaks.valid       = s2_mask_reg != '0;
    assign peaks.peak_row    = out_peak.row;
    assign peaks.peak_col    = out_peak.col;
    assign peaks.last_of_run = s2_single;

    `GLPF_ASSERT_NEVER(a_rot_range, rot_reg == slot_t'(STORES), "store rotation out of range")
    `GLPF_ASSERT(a_row_wrap, in_accept && !flags.c_not_last |=> col_pos_reg == '0,
                 "column counter did not wrap at row end")
    `GLPF_ASSERT(a_rd_hold, s1_valid_reg && !samples.ready |=> $stable(even_q0_reg) &&
                 $stable(odd_q0_reg) && $stable(even_q1_reg) && $stable(odd_q1_reg),
                 "memory read data changed under a stalled decision")
    `GLPF_ASSERT(a_drain, out_accept && !peaks.last_of_run |=>
                 $countones(s2_mask_reg) == $past($countones(s2_mask_reg)) - 1,
                 "pending peak count did not drop by one")

endmodule
